// ----- sv/spq_pkg.sv -----
// Shared types, sizes and codes of the sorted-insert priority queue.
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [15:0] payload_in;
    logic [1:0]  prio_in;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_out;
    logic [4:0]  fill_level;
  } spq_out_t;

  typedef struct packed {
    logic ld_req;
    logic exec;
  } spq_cmd_t;

endpackage

// ----- sv/spq_ctrl.sv -----
// Handshake controller: sequences capture and execution of each request.
module spq_ctrl import spq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output spq_cmd_t cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_ld_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_req |=> state_r == S_EXEC)
    else $error("captured request did not move to execute");

  a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed request produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

endmodule

// ----- sv/spq_dp.sv -----
// Datapath: request register, sorted cell array, entry count and result register.
module spq_dp import spq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  spq_cmd_t cmd,
  input  spq_in_t  in_data,
  output spq_out_t out_data
);

  spq_in_t          req_r;
  spq_out_t         res_r, res_nxt;
  logic [15:0]      pay_r [DEPTH];
  logic [1:0]       pri_r [DEPTH];
  logic [15:0]      pay_nxt [DEPTH];
  logic [1:0]       pri_nxt [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [DEPTH-1:0] keep;
  logic             full, empty;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // A live cell stays put on insert when its priority is at least the new one.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < count_r) && (pri_r[i] >= req_r.prio_in);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      pay_nxt[i] = pay_r[i];
      pri_nxt[i] = pri_r[i];
    end
    count_nxt           = count_r;
    res_nxt.status      = ST_OK;
    res_nxt.payload_out = '0;
    if (req_r.opcode == OP_ENQ) begin
      if (full) begin
        res_nxt.status = ST_OVERFLOW;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        for (int i = 0; i < DEPTH; i++) begin
          if (!keep[i]) begin
            if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
              pay_nxt[i] = req_r.payload_in;
              pri_nxt[i] = req_r.prio_in;
            end else begin
              pay_nxt[i] = pay_r[(i == 0) ? 0 : i - 1];
              pri_nxt[i] = pri_r[(i == 0) ? 0 : i - 1];
            end
          end
        end
      end
    end else begin
      if (empty) begin
        res_nxt.status = ST_EMPTY;
      end else begin
        count_nxt           = count_r - CNT_W'(1);
        res_nxt.payload_out = pay_r[0];
        for (int i = 0; i < DEPTH - 1; i++) begin
          pay_nxt[i] = pay_r[i + 1];
          pri_nxt[i] = pri_r[i + 1];
        end
      end
    end
    res_nxt.fill_level = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        pay_r[i] <= pay_nxt[i];
        pri_r[i] <= pri_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_data = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && req_r.opcode == OP_ENQ && !full)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("enqueue did not grow the count");

  a_empty_deq_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && req_r.opcode == OP_DEQ && empty)
      |=> (count_r == '0 && res_r.status == ST_EMPTY))
    else $error("dequeue on empty changed state or status");

endmodule

// ----- sv/sorted_insert_priority_queue.sv -----
// Top level of the sorted-insert priority queue: controller plus datapath.
//
//   channel  direction  handshake              contents
//   in_      input      in_valid / in_ready    opcode, payload_in, prio_in
//   out_     output     out_valid / out_ready  status, payload_out, fill_level
//
// Each request is captured in S_IDLE, then executed in S_EXEC: the whole cell array
// compares against the new priority and shifts in parallel, or advances on dequeue.
// The result register lets the next request be captured while a result waits;
// execution of that request holds until the waiting result is taken.
// Reset (rst_n low, synchronous) empties the queue; cell contents are not cleared.
module sorted_insert_priority_queue import spq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  spq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output spq_out_t out_data
);

  spq_cmd_t cmd;

  // Sequence capture and execution; hold execution while a result is unread.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Insert behind equal priorities, or drop the head and advance the rest.
  spq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
